// ===== rtl/assert_macros.svh =====
// Assertion macros used by the neighbor table checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define NTAB_CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define NTAB_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ntab_pkg.sv =====
// Shared constants, codes and types of the neighbor table with aging
package ntab_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field widths
	localparam int CMD_W      = 2;
	localparam int IP_W       = 32;
	localparam int PORT_W     = 8;
	localparam int STATUS_W   = 3;
	localparam int TIME_W     = 32;
	localparam int INTERVAL_W = 20;
	localparam int PERIOD_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0]  CFG_EXPIRY_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0]  CFG_SWEEP_PERIOD    = 2'd1;
	localparam logic [INTERVAL_W-1:0] EXPIRY_RESET        = 20'd40000;
	localparam logic [PERIOD_W-1:0]   SWEEP_RESET         = 16'd1000;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_HELLO  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REFRESHED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_EXPIRED    = 3'd5;
	localparam logic [STATUS_W-1:0] ST_QUIET_TICK = 3'd6;

	// One result item
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IP_W-1:0]     ip;
		logic [PORT_W-1:0]   port;
		logic                last;
	} result_t;

endpackage

// ===== rtl/ntab_ram.sv =====
// Generic single-port-write, registered-read synchronous RAM
module ntab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/ntab_walk.sv =====
// Slot walker: reads table entries in slot order for each item and applies hello, remove or sweep
module ntab_walk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ntab_pkg::CMD_W-1:0]          cmd,
	input  logic [ntab_pkg::IP_W-1:0]           ip,
	input  logic [ntab_pkg::PORT_W-1:0]         port,
	input  logic [ntab_pkg::INTERVAL_W-1:0]     interval,
	input  logic [ntab_pkg::PERIOD_W-1:0]       period,
	input  logic                                out_free,
	output logic                                res_valid,
	output ntab_pkg::result_t                   res
);
	import ntab_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

	typedef struct packed {
		logic [IP_W-1:0]   addr;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] expiry;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	state_t                  state_q;
	logic [CMD_W-1:0]        cmd_q;
	logic [IP_W-1:0]         ip_q;
	logic [PORT_W-1:0]       port_q;
	logic [CNT_W-1:0]        rd_idx_q;
	logic [IDX_W-1:0]        idx_s1;
	logic                    vld_s1;
	logic                    free_found_q;
	logic [IDX_W-1:0]        free_idx_q;
	logic [TIME_W-1:0]       time_q;
	logic [PERIOD_W-1:0]     countdown_q;
	logic                    pend_valid_q;
	result_t                 pend_q;
	logic [TABLE_DEPTH-1:0]  slot_valid_q;

	logic [ENTRY_W-1:0]      ram_rdata;
	logic [ENTRY_W-1:0]      ram_wdata;
	entry_t                  rd_entry;
	entry_t                  wr_entry;
	logic [IDX_W-1:0]        ram_raddr;
	logic [IDX_W-1:0]        ram_waddr;
	logic                    ram_we;

	logic                    cur_v;
	logic                    addr_eq;
	logic                    hit_hello;
	logic                    hit_remove;
	logic                    expired;
	logic                    last_slot;
	logic                    sweeping;
	logic                    stall;
	logic                    advance;
	logic                    can_insert;
	logic [IDX_W-1:0]        ins_idx;
	logic [TIME_W-1:0]       new_expiry;
	logic [TIME_W-1:0]       age_diff;

	// Compare the slot whose data has just come out of the RAM
	assign rd_entry   = entry_t'(ram_rdata);
	assign cur_v      = slot_valid_q[idx_s1];
	assign addr_eq    = (rd_entry.addr == ip_q);
	assign hit_hello  = vld_s1 && cur_v && addr_eq;
	assign hit_remove = vld_s1 && cur_v && addr_eq && (rd_entry.port == port_q);
	assign age_diff   = rd_entry.expiry - time_q;
	assign expired    = vld_s1 && cur_v && age_diff[TIME_W-1];
	assign last_slot  = vld_s1 && (idx_s1 == IDX_W'(TABLE_DEPTH - 1));
	assign sweeping   = (state_q == S_WALK) && (cmd_q == CMD_TICK);

	// Hold the walk when an older expiry report cannot leave yet
	assign stall   = sweeping && expired && pend_valid_q && !out_free;
	assign advance = !stall;

	// Re-read the held slot during a stall so its data stays at the RAM output
	assign ram_raddr = advance ? rd_idx_q[IDX_W-1:0] : idx_s1;

	// Insert or refresh write at the end of a hello
	assign new_expiry = time_q + {{(TIME_W - INTERVAL_W){1'b0}}, interval};
	assign can_insert = free_found_q || !cur_v;
	assign ins_idx    = free_found_q ? free_idx_q : idx_s1;
	assign ram_we     = (state_q == S_WALK) && (cmd_q == CMD_HELLO) &&
	                    (hit_hello || (last_slot && can_insert));
	assign ram_waddr  = hit_hello ? idx_s1 : ins_idx;
	assign wr_entry   = '{addr: ip_q, port: port_q, expiry: new_expiry};
	assign ram_wdata  = ENTRY_W'(wr_entry);

	ntab_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE);

	// Emit older expiry reports during the sweep, the final result at the end
	always_comb begin
		res_valid = 1'b0;
		res       = pend_q;
		res.last  = 1'b0;
		if (sweeping && expired && pend_valid_q && out_free) begin
			res_valid = 1'b1;
		end else if (state_q == S_FINISH && out_free) begin
			res_valid = 1'b1;
			res.last  = 1'b1;
			if (!pend_valid_q) begin
				res = '{status: ST_QUIET_TICK, ip: '0, port: '0, last: 1'b1};
			end
		end
	end

	// Sequencer, slot valid bits, clock and sweep countdown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_valid_q <= '0;
			time_q       <= '0;
			countdown_q  <= '0;
			pend_valid_q <= 1'b0;
			vld_s1       <= 1'b0;
			rd_idx_q     <= '0;
			free_found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q        <= cmd;
						ip_q         <= ip;
						port_q       <= port;
						rd_idx_q     <= '0;
						vld_s1       <= 1'b0;
						free_found_q <= 1'b0;
						pend_valid_q <= 1'b0;
						case (cmd)
							CMD_HELLO, CMD_REMOVE: begin
								state_q <= S_WALK;
							end
							CMD_TICK: begin
								time_q <= time_q + TIME_W'(1);
								if (countdown_q != '0) begin
									countdown_q <= countdown_q - PERIOD_W'(1);
									state_q     <= S_FINISH;
								end else begin
									countdown_q <= (period == '0) ? '0 : period - PERIOD_W'(1);
									state_q     <= S_WALK;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (advance) begin
						// Advance the read pointer into the compare stage
						if (rd_idx_q != CNT_W'(TABLE_DEPTH)) begin
							rd_idx_q <= rd_idx_q + CNT_W'(1);
							idx_s1   <= rd_idx_q[IDX_W-1:0];
							vld_s1   <= 1'b1;
						end else begin
							vld_s1 <= 1'b0;
						end
						if (vld_s1) begin
							case (cmd_q)
								CMD_HELLO: begin
									if (hit_hello) begin
										pend_q       <= '{status: ST_REFRESHED, ip: ip_q,
										                  port: port_q, last: 1'b0};
										pend_valid_q <= 1'b1;
										state_q      <= S_FINISH;
									end else if (last_slot) begin
										if (can_insert) begin
											slot_valid_q[ins_idx] <= 1'b1;
											pend_q <= '{status: ST_ADDED, ip: ip_q,
											            port: port_q, last: 1'b0};
										end else begin
											pend_q <= '{status: ST_FULL, ip: ip_q,
											            port: port_q, last: 1'b0};
										end
										pend_valid_q <= 1'b1;
										state_q      <= S_FINISH;
									end else if (!cur_v && !free_found_q) begin
										free_found_q <= 1'b1;
										free_idx_q   <= idx_s1;
									end
								end
								CMD_REMOVE: begin
									if (hit_remove) begin
										slot_valid_q[idx_s1] <= 1'b0;
										pend_q       <= '{status: ST_REMOVED, ip: ip_q,
										                  port: port_q, last: 1'b0};
										pend_valid_q <= 1'b1;
										state_q      <= S_FINISH;
									end else if (last_slot) begin
										pend_q       <= '{status: ST_NOT_FOUND, ip: ip_q,
										                  port: port_q, last: 1'b0};
										pend_valid_q <= 1'b1;
										state_q      <= S_FINISH;
									end
								end
								default: begin
									// Sweep: drop expired slots, keep the newest report pending
									if (expired) begin
										slot_valid_q[idx_s1] <= 1'b0;
										pend_q       <= '{status: ST_EXPIRED, ip: rd_entry.addr,
										                  port: rd_entry.port, last: 1'b0};
										pend_valid_q <= 1'b1;
									end
									if (last_slot) begin
										state_q <= S_FINISH;
									end
								end
							endcase
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/neighbour_table_with_aging_unit.sv =====
// Neighbor table with aging: an item takes one pass over the table through a
// single registered RAM read port, one slot per cycle unless a sweep stalls on
// the output, then hands its result to the output register and returns to idle,
// where the next item is taken. Hello and remove end early on a match; a tick
// that does not sweep skips the pass. Any item is held while one of its results
// finds the one-entry output register still occupied. Hello refreshes or inserts
// at the lowest free slot, remove deletes on address and port match, tick
// advances the millisecond clock and sweeps every sweep_period_ms ticks,
// reporting expired slots in slot order with last set on the final result of
// each item. Configuration writes are always taken and must occur only while
// the block is idle.
module neighbour_table_with_aging_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ntab_pkg::CMD_W-1:0]          cmd,
	input  logic [ntab_pkg::IP_W-1:0]           neighbor_ip,
	input  logic [ntab_pkg::PORT_W-1:0]         port_number,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ntab_pkg::STATUS_W-1:0]       status,
	output logic [ntab_pkg::IP_W-1:0]           out_ip,
	output logic [ntab_pkg::PORT_W-1:0]         out_port,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ntab_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ntab_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ntab_pkg::*;

	logic [INTERVAL_W-1:0] interval_q;
	logic [PERIOD_W-1:0]   period_q;
	logic                  out_valid_q;
	result_t               out_res_q;
	logic                  out_free;
	logic                  res_valid;
	result_t               res;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= EXPIRY_RESET;
			period_q   <= SWEEP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_EXPIRY_INTERVAL: interval_q <= cfg_data[INTERVAL_W-1:0];
				CFG_SWEEP_PERIOD:    period_q   <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	ntab_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.ip        (neighbor_ip),
		.port      (port_number),
		.interval  (interval_q),
		.period    (period_q),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: load a new result, drop it on transfer
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_res_q.status;
	assign out_ip    = out_res_q.ip;
	assign out_port  = out_res_q.port;
	assign last      = out_res_q.last;

endmodule

// ===== rtl/ntab_checker.sv =====
// Port-level checker for the neighbor table, bound to the top level
`include "assert_macros.svh"

module ntab_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [ntab_pkg::CMD_W-1:0]          cmd,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [ntab_pkg::STATUS_W-1:0]       status,
	input logic [ntab_pkg::IP_W-1:0]           out_ip,
	input logic [ntab_pkg::PORT_W-1:0]         out_port,
	input logic                                last
);
	import ntab_pkg::*;

	// A stalled result holds
	`NTAB_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(out_ip) && $stable(out_port) && $stable(last), "stalled result changed")

	// Only expiry reports may be followed by more results of the same item
	`NTAB_CHK_SAME(a_single_last, out_valid && status != ST_EXPIRED, last, "non-expiry result without last")

	// A quiet tick reports no entry
	`NTAB_CHK_SAME(a_quiet_zero, out_valid && status == ST_QUIET_TICK, out_ip == '0 && out_port == '0, "quiet tick with nonzero entry")

	// A valid command keeps the block busy for at least the next cycle
	`NTAB_CHK_NEXT(a_busy_after, in_valid && in_ready && cmd != CMD_UNUSED, !in_ready, "ready right after a command")

endmodule

bind neighbour_table_with_aging_unit ntab_checker u_ntab_checker (.*);

// ===== dv/neighbour_table_with_aging_unit_test.sv =====
// Self-checking testbench for the aging neighbor table unit
`timescale 1ns / 100ps

module neighbour_table_with_aging_unit_test;
	import ntab_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 3000;
	localparam int POOL_SIZE    = 20;

	// Register indexes that map to no register
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One directed step: an item, or a register write with ip as write data
	typedef struct packed {
		row_kind_t             kind;
		logic [CMD_W-1:0]      cmd;
		logic [CFG_IDX_W-1:0]  idx;
		logic [IP_W-1:0]       ip;
		logic [PORT_W-1:0]     port;
		logic                  known;
		logic [STATUS_W-1:0]   st;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [CMD_W-1:0]       cmd;
	logic [IP_W-1:0]        neighbor_ip;
	logic [PORT_W-1:0]      port_number;
	logic                   out_valid;
	logic                   out_ready;
	logic [STATUS_W-1:0]    status;
	logic [IP_W-1:0]        out_ip;
	logic [PORT_W-1:0]      out_port;
	logic                   last;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Shadow copy of the table, its clock and its registers
	logic                   nb_valid [TABLE_DEPTH];
	logic [IP_W-1:0]        nb_addr [TABLE_DEPTH];
	logic [PORT_W-1:0]      nb_port [TABLE_DEPTH];
	logic [TIME_W-1:0]      nb_expiry [TABLE_DEPTH];
	logic [TIME_W-1:0]      clock_ms;
	logic [PERIOD_W-1:0]    sweep_left;
	logic [INTERVAL_W-1:0]  life_ms;
	logic [PERIOD_W-1:0]    sweep_ms;

	result_t                pending_results [$];
	result_t                head;
	logic [IP_W-1:0]        addr_pool [POOL_SIZE];
	stim_row_t              dir_rows [24];

	logic                   idle_on;
	logic                   hold_req;
	int                     err_count;
	int                     quiet_cycles;
	int                     n_items;
	int                     n_results;
	int                     n_expired;
	int                     n_full;
	int                     n_settings;

	neighbour_table_with_aging_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.neighbor_ip (neighbor_ip),
		.port_number (port_number),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.out_ip      (out_ip),
		.out_port    (out_port),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Apply one item to the shadow table; queue its results when keep is set
	function automatic void table_step(input logic [CMD_W-1:0] c, input logic [IP_W-1:0] a,
			input logic [PORT_W-1:0] p, input bit keep);
		result_t            outs [$];
		result_t            r;
		int                 i;
		int                 free_slot;
		bit                 hit;
		logic [TIME_W-1:0]  diff;
		logic [PERIOD_W-1:0] per;
		free_slot = -1;
		hit = 1'b0;
		case (c)
			CMD_HELLO: begin
				for (i = 0; i < TABLE_DEPTH && !hit; i++) begin
					if (nb_valid[i] && nb_addr[i] == a) begin
						nb_port[i] = p;
						nb_expiry[i] = clock_ms + life_ms;
						hit = 1'b1;
					end else if (!nb_valid[i] && free_slot < 0) begin
						free_slot = i;
					end
				end
				if (hit) begin
					r = '{ST_REFRESHED, a, p, 1'b1};
				end else if (free_slot < 0) begin
					r = '{ST_FULL, a, p, 1'b1};
				end else begin
					nb_valid[free_slot] = 1'b1;
					nb_addr[free_slot] = a;
					nb_port[free_slot] = p;
					nb_expiry[free_slot] = clock_ms + life_ms;
					r = '{ST_ADDED, a, p, 1'b1};
				end
				outs.insert(outs.size(), r);
			end
			CMD_REMOVE: begin
				for (i = 0; i < TABLE_DEPTH && !hit; i++) begin
					if (nb_valid[i] && nb_addr[i] == a && nb_port[i] == p) begin
						nb_valid[i] = 1'b0;
						hit = 1'b1;
					end
				end
				r = '{hit ? ST_REMOVED : ST_NOT_FOUND, a, p, 1'b1};
				outs.insert(outs.size(), r);
			end
			CMD_TICK: begin
				clock_ms = clock_ms + 1;
				if (sweep_left != '0) begin
					sweep_left = sweep_left - PERIOD_W'(1);
				end else begin
					// reload the countdown, then drop every slot past its expiry
					per = (sweep_ms == '0) ? 16'd1 : sweep_ms;
					sweep_left = per - PERIOD_W'(1);
					for (i = 0; i < TABLE_DEPTH; i++) begin
						diff = nb_expiry[i] - clock_ms;
						if (nb_valid[i] && diff[TIME_W-1]) begin
							nb_valid[i] = 1'b0;
							r = '{ST_EXPIRED, nb_addr[i], nb_port[i], 1'b0};
							outs.insert(outs.size(), r);
						end
					end
				end
				if (outs.size() == 0) begin
					r = '{ST_QUIET_TICK, '0, '0, 1'b1};
					outs.insert(outs.size(), r);
				end else begin
					outs[outs.size()-1].last = 1'b1;
				end
			end
			default: ;
		endcase
		if (keep)
			foreach (outs[n])
				pending_results.insert(pending_results.size(), outs[n]);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
		err_count++;
	endtask

	// Drop valid, drain all pending results, then let any silent item finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		if (idx == CFG_EXPIRY_INTERVAL)
			life_ms = data[INTERVAL_W-1:0];
		else if (idx == CFG_SWEEP_PERIOD)
			sweep_ms = data[PERIOD_W-1:0];
	endtask

	// Offer one item and hold it until the transfer; typed rows queue their own result
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [IP_W-1:0] a,
			input logic [PORT_W-1:0] p, input bit known, input logic [STATUS_W-1:0] st);
		result_t typed;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		neighbor_ip <= a;
		port_number <= p;
		do @(posedge clk); while (in_ready !== 1'b1);
		table_step(c, a, p, !known);
		if (known) begin
			typed.status = st;
			typed.ip = (st == ST_QUIET_TICK) ? '0 : a;
			typed.port = (st == ST_QUIET_TICK) ? '0 : p;
			typed.last = 1'b1;
			pending_results.insert(pending_results.size(), typed);
		end
		if (c != CMD_UNUSED)
			n_items++;
	endtask

	// One register setting followed by a random mix of hellos, removes, ticks and unused commands
	task automatic run_phase(input int life, input int period, input int count,
			input int tick_pct, input int hello_pct, input bit pressure);
		int                done_items;
		int                k;
		int                j;
		int                live [$];
		logic [CMD_W-1:0]  c;
		logic [IP_W-1:0]   a;
		logic [PORT_W-1:0] p;
		write_reg(CFG_EXPIRY_INTERVAL, life);
		write_reg(CFG_SWEEP_PERIOD, period);
		n_settings++;
		if (pressure)
			hold_req = 1'b1;
		done_items = 0;
		while (done_items < count) begin
			a = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, POOL_SIZE-1)];
			p = PORT_W'($urandom_range(0, 255));
			k = $urandom_range(0, 99);
			if (k < 3) begin
				c = CMD_UNUSED;
			end else if (k < 3 + tick_pct) begin
				c = CMD_TICK;
			end else if ($urandom_range(0, 99) < hello_pct) begin
				c = CMD_HELLO;
			end else begin
				// mostly hit a live entry, otherwise probe with the randomly drawn address
				c = CMD_REMOVE;
				live.delete();
				for (j = 0; j < TABLE_DEPTH; j++)
					if (nb_valid[j])
						live.insert(live.size(), j);
				if (live.size() > 0 && $urandom_range(0, 3) != 0) begin
					j = live[$urandom_range(0, live.size()-1)];
					a = nb_addr[j];
					p = nb_port[j];
				end
			end
			send_item(c, a, p, 1'b0, ST_ADDED);
			if (c != CMD_UNUSED)
				done_items++;
		end
	endtask

	// Result sink: random stall bursts, plus one long hold when requested
	initial begin
		int stall_left;
		out_ready = 1'b0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= (stall_left == 0);
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Check each result transfer against the oldest expectation; watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (out_valid && out_ready) begin
				n_results++;
				if (status == ST_EXPIRED)
					n_expired++;
				if (status == ST_FULL)
					n_full++;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, status", 32'(status), '0);
				end else begin
					head = pending_results.pop_front();
					if (status !== head.status)
						report_mismatch("status", 32'(status), 32'(head.status));
					if (out_ip !== head.ip)
						report_mismatch("out_ip", out_ip, head.ip);
					if (out_port !== head.port)
						report_mismatch("out_port", 32'(out_port), 32'(head.port));
					if (last !== head.last)
						report_mismatch("last", 32'(last), 32'(head.last));
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		in_valid = 1'b0;
		cmd = CMD_HELLO;
		neighbor_ip = '0;
		port_number = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_EXPIRY_INTERVAL;
		cfg_data = '0;
		arst_n = 1'b0;
		hold_req = 1'b0;
		idle_on = 1'b1;
		err_count = 0;
		quiet_cycles = 0;
		n_items = 0;
		n_results = 0;
		n_expired = 0;
		n_full = 0;
		n_settings = 1;
		foreach (nb_valid[i])
			nb_valid[i] = 1'b0;
		clock_ms = '0;
		sweep_left = '0;
		life_ms = EXPIRY_RESET;
		sweep_ms = SWEEP_RESET;
		foreach (addr_pool[i])
			addr_pool[i] = $urandom;

		// Directed steps: extremes, every command, zero registers, multi-entry expiry
		dir_rows = '{
			'{ROW_ITEM, CMD_HELLO,  CFG_EXPIRY_INTERVAL, 32'h00000000, 8'h00, 1'b1, ST_ADDED},
			'{ROW_ITEM, CMD_HELLO,  CFG_EXPIRY_INTERVAL, 32'hFFFFFFFF, 8'hFF, 1'b1, ST_ADDED},
			'{ROW_ITEM, CMD_HELLO,  CFG_EXPIRY_INTERVAL, 32'hFFFFFFFF, 8'h5A, 1'b1, ST_REFRESHED},
			'{ROW_ITEM, CMD_REMOVE, CFG_EXPIRY_INTERVAL, 32'hFFFFFFFF, 8'hFF, 1'b1, ST_NOT_FOUND},
			'{ROW_ITEM, CMD_REMOVE, CFG_EXPIRY_INTERVAL, 32'hFFFFFFFF, 8'h5A, 1'b1, ST_REMOVED},
			'{ROW_ITEM, CMD_UNUSED, CFG_EXPIRY_INTERVAL, 32'h13579BDF, 8'h3C, 1'b0, ST_ADDED},
			'{ROW_CFG,  CMD_HELLO,  CFG_UNMAPPED_HI,     32'hFFFFFFFF, 8'h00, 1'b0, ST_ADDED},
			'{ROW_CFG,  CMD_HELLO,  CFG_UNMAPPED_LO,     32'h00000000, 8'h00, 1'b0, ST_ADDED},
			'{ROW_CFG,  CMD_HELLO,  CFG_SWEEP_PERIOD,    32'd0,        8'h00, 1'b0, ST_ADDED},
			'{ROW_CFG,  CMD_HELLO,  CFG_EXPIRY_INTERVAL, 32'd0,        8'h00, 1'b0, ST_ADDED},
			'{ROW_ITEM, CMD_HELLO,  CFG_EXPIRY_INTERVAL, 32'h12345678, 8'h01, 1'b1, ST_ADDED},
			'{ROW_ITEM, CMD_TICK,   CFG_EXPIRY_INTERVAL, 32'hDEADBEEF, 8'h77, 1'b0, ST_ADDED},
			'{ROW_CFG,  CMD_HELLO,  CFG_EXPIRY_INTERVAL, 32'd1,        8'h00, 1'b0, ST_ADDED},
			'{ROW_ITEM, CMD_HELLO,  CFG_EXPIRY_INTERVAL, 32'h87654321, 8'h80, 1'b1, ST_ADDED},
			'{ROW_ITEM, CMD_TICK,   CFG_EXPIRY_INTERVAL, 32'h00000000, 8'h00, 1'b1, ST_QUIET_TICK},
			'{ROW_ITEM, CMD_TICK,   CFG_EXPIRY_INTERVAL, 32'h00000000, 8'h00, 1'b0, ST_ADDED},
			'{ROW_ITEM, CMD_HELLO,  CFG_EXPIRY_INTERVAL, 32'h00000000, 8'hFF, 1'b1, ST_REFRESHED},
			'{ROW_ITEM, CMD_HELLO,  CFG_EXPIRY_INTERVAL, 32'hAAAAAAAA, 8'h55, 1'b1, ST_ADDED},
			'{ROW_ITEM, CMD_TICK,   CFG_EXPIRY_INTERVAL, 32'hCAFEF00D, 8'hAA, 1'b1, ST_QUIET_TICK},
			'{ROW_ITEM, CMD_TICK,   CFG_EXPIRY_INTERVAL, 32'h00000000, 8'h00, 1'b0, ST_ADDED},
			'{ROW_CFG,  CMD_HELLO,  CFG_EXPIRY_INTERVAL, 32'd1000000,  8'h00, 1'b0, ST_ADDED},
			'{ROW_CFG,  CMD_HELLO,  CFG_SWEEP_PERIOD,    32'd65535,    8'h00, 1'b0, ST_ADDED},
			'{ROW_ITEM, CMD_HELLO,  CFG_EXPIRY_INTERVAL, 32'hFFFFFFFF, 8'h00, 1'b1, ST_ADDED},
			'{ROW_ITEM, CMD_REMOVE, CFG_EXPIRY_INTERVAL, 32'h00000000, 8'h00, 1'b1, ST_NOT_FOUND}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG)
				write_reg(dir_rows[r].idx, dir_rows[r].ip);
			else
				send_item(dir_rows[r].cmd, dir_rows[r].ip, dir_rows[r].port,
					dir_rows[r].known, dir_rows[r].st);
		end

		// Random phases; the long result hold lands in the hello-heavy one
		run_phase(1,       1,     30, 35, 60, 1'b0);
		run_phase(0,       0,     30, 35, 60, 1'b0);
		run_phase(7,       3,     35, 30, 60, 1'b0);
		run_phase(500000,  1,     40, 10, 85, 1'b1);
		run_phase(25,      2,     35, 30, 70, 1'b0);
		idle_on = 1'b0;
		run_phase(1000000, 65535, 35, 20, 70, 1'b0);

		wait_idle();
		$display("Run covered %0d items over %0d register settings, %0d results checked.",
			n_items, n_settings, n_results);
		$display("Expiry reports seen: %0d, table-full replies seen: %0d, mismatches: %0d.",
			n_expired, n_full, err_count);
		if (err_count == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ntab_pkg.sv
rtl/ntab_ram.sv
rtl/ntab_walk.sv
rtl/neighbour_table_with_aging_unit.sv
rtl/ntab_checker.sv
dv/neighbour_table_with_aging_unit_test.sv
